/* hdl/tte_pkg.sv */
package tte_pkg;

   localparam int HISTORY_DEPTH_DEF = 4;

   localparam int TAP_W      = 32;
   localparam int QP_W       = 16;
   localparam int USED_W     = 2;
   localparam int TOL_W      = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int PCT_SCALE  = 100;
   localparam int DIV_STEPS  = 32;
   localparam int DIV_CNT_W  = 6;

   localparam logic [QP_W-1:0]  MAX_QP_RESET = 16'd2000;
   localparam logic [TOL_W-1:0] TOL_RESET    = 7'd10;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_QUARTER_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE_PERCENT  = 2'd1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FILL,
      S_GAP,
      S_SCAN,
      S_READ,
      S_CMP,
      S_SPAN,
      S_DIV,
      S_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_first;
      logic gap_load;
      logic prod_load;
      logic count_inc;
      logic div_start;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic enough_taps;
      logic gap_too_long;
      logic scan_done;
      logic close;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

/* hdl/tte_ctrl.sv */
module tte_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tte_pkg::status_type status,
   output tte_pkg::cmd_type    cmd
);

   tte_pkg::state_type state_ff;
   tte_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tte_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tte_pkg::S_IDLE: begin
            if (req_valid) state_in = tte_pkg::S_FILL;
         end
         tte_pkg::S_FILL: begin
            state_in = status.enough_taps ? tte_pkg::S_GAP : tte_pkg::S_IDLE;
         end
         tte_pkg::S_GAP: begin
            state_in = status.gap_too_long ? tte_pkg::S_IDLE : tte_pkg::S_SCAN;
         end
         tte_pkg::S_SCAN: begin
            state_in = status.scan_done ? tte_pkg::S_SPAN : tte_pkg::S_READ;
         end
         tte_pkg::S_READ: begin
            state_in = tte_pkg::S_CMP;
         end
         tte_pkg::S_CMP: begin
            state_in = status.close ? tte_pkg::S_SCAN : tte_pkg::S_SPAN;
         end
         tte_pkg::S_SPAN: begin
            state_in = tte_pkg::S_DIV;
         end
         tte_pkg::S_DIV: begin
            if (status.div_done) state_in = tte_pkg::S_OUT;
         end
         tte_pkg::S_OUT: begin
            if (status.out_free) state_in = tte_pkg::S_IDLE;
         end
         default: begin
            state_in = tte_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         tte_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         tte_pkg::S_FILL: begin
            cmd.rd_first = 1'b1;
         end
         tte_pkg::S_GAP: begin
            cmd.gap_load = 1'b1;
         end
         tte_pkg::S_SCAN: begin
            cmd.rd_first = 1'b0;
         end
         tte_pkg::S_READ: begin
            cmd.prod_load = 1'b1;
         end
         tte_pkg::S_CMP: begin
            cmd.count_inc = status.close;
         end
         tte_pkg::S_SPAN: begin
            cmd.div_start = 1'b1;
         end
         tte_pkg::S_DIV: begin
            cmd.div_step = !status.div_done;
         end
         tte_pkg::S_OUT: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* hdl/tte_dp.sv */
module tte_dp #(
   parameter int HISTORY_DEPTH = tte_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [tte_pkg::TAP_W-1:0]         req_tap_time,
   input  logic                              csr_wr_en,
   input  logic [tte_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tte_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [tte_pkg::TAP_W-1:0]         rsp_beat_time,
   output logic [tte_pkg::QP_W-1:0]          rsp_quarter_period,
   output logic [tte_pkg::USED_W-1:0]        rsp_intervals_used,
   input  tte_pkg::cmd_type                  cmd,
   output tte_pkg::status_type               status
);

   localparam int SLOT_W = $clog2(HISTORY_DEPTH);
   localparam int BACK_W = SLOT_W + 1;
   localparam int CNT_W  = SLOT_W;
   localparam int VT_W   = $clog2(HISTORY_DEPTH + 1);
   localparam int TAP_W  = tte_pkg::TAP_W;
   localparam int QP_W   = tte_pkg::QP_W;
   localparam int TOL_W  = tte_pkg::TOL_W;
   localparam int LHS_W  = TAP_W + 7;
   localparam int RHS_W  = QP_W + TOL_W + 1;

   // tap ring
   logic [TAP_W-1:0]  tap_mem [HISTORY_DEPTH];
   logic [TAP_W-1:0]  rd_data_ff;
   logic [SLOT_W-1:0] rd_addr;
   logic [BACK_W-1:0] rd_back;
   logic [BACK_W-1:0] slot_ext;

   // control registers
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [VT_W-1:0]   valid_taps_ff, valid_taps_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [QP_W-1:0]   max_qp_ff, max_qp_in;
   logic [TOL_W-1:0]  tol_ff, tol_in;

   // working registers
   logic [TAP_W-1:0]  now_ff, now_in;
   logic [TAP_W-1:0]  prev_tap_ff, prev_tap_in;
   logic [TAP_W-1:0]  cand_ff, cand_in;
   logic [QP_W-1:0]   gap_ff, gap_in;
   logic [LHS_W-1:0]  lhs_ff, lhs_in;
   logic [RHS_W-1:0]  rhs_ff, rhs_in;

   // divider
   logic [TAP_W-1:0]             quo_ff, quo_in;
   logic [CNT_W-1:0]             rem_ff, rem_in;
   logic [tte_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [CNT_W:0]               trial;
   logic                         trial_ge;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [TAP_W-1:0]    rsp_beat_ff, rsp_beat_in;
   logic [QP_W-1:0]     rsp_qp_ff, rsp_qp_in;
   logic [tte_pkg::USED_W-1:0] rsp_used_ff, rsp_used_in;

   logic [TAP_W-1:0] newest_gap;
   logic [TAP_W-1:0] cand_gap;
   logic [TAP_W-1:0] diff;
   logic [TAP_W-1:0] span;
   logic [SLOT_W-1:0] slot_next;

   assign slot_next = (slot_ff == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + 1'b1;

   // ring index of the tap rd_back steps older than the newest one
   assign rd_back  = cmd.rd_first ? BACK_W'(1) : {1'b0, count_ff} + BACK_W'(1);
   assign slot_ext = {1'b0, slot_ff};
   always_comb begin
      if (slot_ext >= rd_back) begin
         rd_addr = SLOT_W'(slot_ext - rd_back);
      end else begin
         rd_addr = SLOT_W'(slot_ext + BACK_W'(HISTORY_DEPTH) - rd_back);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tap_mem[slot_next] <= req_tap_time;
      end
      rd_data_ff <= tap_mem[rd_addr];
   end

   assign newest_gap = now_ff - rd_data_ff;
   assign cand_gap   = prev_tap_ff - rd_data_ff;
   assign diff       = (cand_gap >= TAP_W'(gap_ff)) ? cand_gap - TAP_W'(gap_ff)
                                                     : TAP_W'(gap_ff) - cand_gap;
   assign span       = now_ff - prev_tap_ff;

   assign trial    = {rem_ff, quo_ff[TAP_W-1]};
   assign trial_ge = trial >= {1'b0, count_ff};

   always_comb begin
      slot_in       = slot_ff;
      valid_taps_in = valid_taps_ff;
      count_in      = count_ff;
      now_in        = now_ff;
      prev_tap_in   = prev_tap_ff;
      cand_in       = cand_ff;
      gap_in        = gap_ff;
      lhs_in        = lhs_ff;
      rhs_in        = rhs_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      max_qp_in     = max_qp_ff;
      tol_in        = tol_ff;

      if (csr_wr_en) begin
         case (csr_index)
            tte_pkg::CSR_MAX_QUARTER_PERIOD: max_qp_in = csr_wdata[QP_W-1:0];
            tte_pkg::CSR_TOLERANCE_PERCENT:  tol_in    = csr_wdata[TOL_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         slot_in  = slot_next;
         now_in   = req_tap_time;
         count_in = CNT_W'(1);
         if (valid_taps_ff < VT_W'(HISTORY_DEPTH)) begin
            valid_taps_in = valid_taps_ff + 1'b1;
         end
      end

      if (cmd.gap_load) begin
         gap_in      = newest_gap[QP_W-1:0];
         prev_tap_in = rd_data_ff;
      end

      if (cmd.prod_load) begin
         cand_in = rd_data_ff;
         lhs_in  = LHS_W'(diff) * LHS_W'(tte_pkg::PCT_SCALE);
         rhs_in  = (RHS_W'(tol_ff) + RHS_W'(1)) * RHS_W'(gap_ff);
      end

      if (cmd.count_inc) begin
         count_in    = count_ff + 1'b1;
         prev_tap_in = cand_ff;
      end

      if (cmd.div_start) begin
         quo_in     = span;
         rem_in     = '0;
         div_cnt_in = tte_pkg::DIV_CNT_W'(tte_pkg::DIV_STEPS);
      end else if (cmd.div_step) begin
         quo_in     = {quo_ff[TAP_W-2:0], trial_ge};
         rem_in     = trial_ge ? CNT_W'(trial - {1'b0, count_ff}) : CNT_W'(trial);
         div_cnt_in = div_cnt_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;
      rsp_qp_in    = rsp_qp_ff;
      rsp_used_in  = rsp_used_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_beat_in  = now_ff;
         rsp_qp_in    = (|quo_ff[TAP_W-1:QP_W]) ? '1 : quo_ff[QP_W-1:0];
         rsp_used_in  = tte_pkg::USED_W'(count_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff       <= '0;
         valid_taps_ff <= '0;
         count_ff      <= CNT_W'(1);
         div_cnt_ff    <= '0;
         max_qp_ff     <= tte_pkg::MAX_QP_RESET;
         tol_ff        <= tte_pkg::TOL_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_ff       <= slot_in;
         valid_taps_ff <= valid_taps_in;
         count_ff      <= count_in;
         div_cnt_ff    <= div_cnt_in;
         max_qp_ff     <= max_qp_in;
         tol_ff        <= tol_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      prev_tap_ff <= prev_tap_in;
      cand_ff     <= cand_in;
      gap_ff      <= gap_in;
      lhs_ff      <= lhs_in;
      rhs_ff      <= rhs_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      rsp_beat_ff <= rsp_beat_in;
      rsp_qp_ff   <= rsp_qp_in;
      rsp_used_ff <= rsp_used_in;
   end

   assign status.enough_taps  = valid_taps_ff >= VT_W'(2);
   assign status.gap_too_long = newest_gap > TAP_W'(max_qp_ff);
   assign status.scan_done    = (32'(count_ff) >= 32'(HISTORY_DEPTH - 1))
                             || (32'(count_ff) + 32'd1 >= 32'(valid_taps_ff))
                             || (gap_ff == '0);
   // floor(diff*100/n) <= tol  is  diff*100 < (tol+1)*n
   assign status.close        = lhs_ff < LHS_W'(rhs_ff);
   assign status.div_done     = div_cnt_ff == '0;
   assign status.out_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_beat_time      = rsp_beat_ff;
   assign rsp_quarter_period = rsp_qp_ff;
   assign rsp_intervals_used = rsp_used_ff;

`ifndef SYNTHESIS
   a_valid_taps_bound: assert property (@(posedge clock) disable iff (reset)
      valid_taps_ff <= VT_W'(HISTORY_DEPTH))
      else $error("valid tap count beyond ring depth");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (32'(count_ff) <= 32'(HISTORY_DEPTH - 1)))
      else $error("interval count out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while still held");

   a_load_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (valid_taps_ff != '0))
      else $error("tap count not advanced after load");
`endif

endmodule

/* hdl/tap_tempo_estimator_core.sv */
// Channel   Ports                                   Direction  Moves
// -------   -------------------------------------   ---------  -----------------------------
// req       req_valid/req_ready, req_tap_time       in         one tap timestamp per item
// rsp       rsp_valid/rsp_ready, rsp_beat_time,     out        zero or one tempo item per tap
//           rsp_quarter_period, rsp_intervals_used
// csr       csr_wr_en, csr_index, csr_wdata         in         register write, no wait
//
// The 32-step serial divider for the average takes most of an item's time, and
// the tap ring gives one read per scan step.
// One item is in work at a time; the next is taken once the result is in the
// output register, while that result may still wait for rsp_ready.
// Synchronous active-high reset empties the tap ring count and restores the registers.
module tap_tempo_estimator_core #(
   parameter int HISTORY_DEPTH = tte_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [tte_pkg::TAP_W-1:0]      req_tap_time,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [tte_pkg::TAP_W-1:0]      rsp_beat_time,
   output logic [tte_pkg::QP_W-1:0]       rsp_quarter_period,
   output logic [tte_pkg::USED_W-1:0]     rsp_intervals_used,
   input  logic                           csr_wr_en,
   input  logic [tte_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tte_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // Controller sequences: take the tap, check fill, form the newest interval,
   // scan older intervals newest first, divide the span, hand off the item.
   tte_pkg::cmd_type    cmd;
   tte_pkg::status_type status;

   tte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath holds the tap ring, the registers, the tolerance products,
   // the serial divider and the output register.
   tte_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_tap_time       (req_tap_time),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_beat_time      (rsp_beat_time),
      .rsp_quarter_period (rsp_quarter_period),
      .rsp_intervals_used (rsp_intervals_used),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

/* tb/tb_tap_tempo_estimator_core.sv */
module tb_tap_tempo_estimator_core;

   // Ring depth of the block as built; the predictor keeps its own ring of the same size.
   localparam int RING_DEPTH = tte_pkg::HISTORY_DEPTH_DEF;

   // Register indexes past the two real registers: writes there must change nothing.
   localparam logic [tte_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [tte_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int DRAIN_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 64;    // longer than one item takes
   localparam int HOLD_OFF_LEN  = 400;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_TAPS    = 250;
   localparam int MAX_WAIT      = 16;

   typedef struct packed {
      logic [tte_pkg::TAP_W-1:0]  beat_time;
      logic [tte_pkg::QP_W-1:0]   quarter_period;
      logic [tte_pkg::USED_W-1:0] intervals_used;
   } tempo_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [tte_pkg::TAP_W-1:0]      req_tap_time = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [tte_pkg::TAP_W-1:0]      rsp_beat_time;
   logic [tte_pkg::QP_W-1:0]       rsp_quarter_period;
   logic [tte_pkg::USED_W-1:0]     rsp_intervals_used;
   logic                           csr_wr_en = 1'b0;
   logic [tte_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [tte_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor state: the tap ring, its head and fill count, and the two registers.
   logic [tte_pkg::TAP_W-1:0] tap_ring [RING_DEPTH];
   int                        ring_head;
   int                        ring_fill;
   logic [tte_pkg::QP_W-1:0]  cfg_max_period;
   logic [tte_pkg::TOL_W-1:0] cfg_tol_pct;

   // Expected tempo items, oldest first.
   tempo_type pending_tempo [$];
   tempo_type tempo_want;

   logic [tte_pkg::TAP_W-1:0] tap_clock = '0;     // time stamp of the last tap sent
   bit               tap_gaps_on = 1'b1;
   bit               rsp_stalls_on = 1'b1;
   int               rsp_stall_left = 0;
   int               rsp_freeze_len = 0;
   bit               rsp_frozen = 1'b0;

   int mismatch_count = 0;
   int taps_sent = 0;
   int tempo_checked = 0;
   int csr_writes = 0;
   int cycle_count = 0;

   tap_tempo_estimator_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_tap_time       (req_tap_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_beat_time      (rsp_beat_time),
      .rsp_quarter_period (rsp_quarter_period),
      .rsp_intervals_used (rsp_intervals_used),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   // Stop a hung run: a correct run needs a small fraction of this.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d tempo items still expected",
                  cycle_count, pending_tempo.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // Tap time that lies back steps behind the newest tap in the predictor ring.
   function automatic logic [tte_pkg::TAP_W-1:0] tap_back(input int back);
      return tap_ring[(ring_head + RING_DEPTH - back) % RING_DEPTH];
   endfunction

   // Push one tap into the predictor ring and queue the tempo item it causes, if any.
   task automatic predict_tempo(input logic [tte_pkg::TAP_W-1:0] now);
      logic [tte_pkg::TAP_W-1:0] newest;
      logic [tte_pkg::TAP_W-1:0] older;
      logic [tte_pkg::TAP_W-1:0] diff;
      logic [tte_pkg::TAP_W-1:0] span;
      logic [tte_pkg::TAP_W-1:0] avg;
      logic [63:0]               pct;
      int                        used;
      bit                        stop;
      tempo_type                 item;

      ring_head = (ring_head + 1) % RING_DEPTH;
      tap_ring[ring_head] = now;
      if (ring_fill < RING_DEPTH) ring_fill++;
      // Need two taps for an interval.
      if (ring_fill < 2) return;
      newest = now - tap_back(1);
      if (newest > tte_pkg::TAP_W'(cfg_max_period)) return;

      // Accept older intervals, newest first, while they stay within tolerance.
      // Stop at unwritten entries, and at once when the newest interval is zero.
      used = 1;
      stop = 1'b0;
      while (!stop && used < RING_DEPTH - 1) begin
         if (used + 1 >= ring_fill || newest == '0) begin
            stop = 1'b1;
         end else begin
            older = tap_back(used) - tap_back(used + 1);
            diff  = (older >= newest) ? older - newest : newest - older;
            pct   = (64'(diff) * 64'(tte_pkg::PCT_SCALE)) / 64'(newest);
            if (pct > 64'(cfg_tol_pct)) stop = 1'b1;
            else used++;
         end
      end

      span = now - tap_back(used);
      avg  = span / tte_pkg::TAP_W'(used);
      item.beat_time      = now;
      item.quarter_period = (avg > tte_pkg::TAP_W'(16'hFFFF)) ? 16'hFFFF
                                                              : avg[tte_pkg::QP_W-1:0];
      item.intervals_used = tte_pkg::USED_W'(used);
      pending_tempo.push_back(item);
   endtask

   // Offer one tap, after a random gap when gaps are on, and hold it until the block takes it.
   // Valid stays high on return, so a back-to-back tap keeps it high.
   task automatic send_tap(input logic [tte_pkg::TAP_W-1:0] stamp);
      int gap;
      gap = tap_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid    = 1'b1;
      req_tap_time = stamp;
      do @(posedge clock); while (!req_ready);
      predict_tempo(stamp);
      tap_clock = stamp;
      taps_sent++;
   endtask

   task automatic tap_after(input logic [tte_pkg::TAP_W-1:0] interval);
      send_tap(tap_clock + interval);
   endtask

   // Write one register; only called while the block is idle.
   task automatic write_csr(input logic [tte_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tte_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         tte_pkg::CSR_MAX_QUARTER_PERIOD: cfg_max_period = data[tte_pkg::QP_W-1:0];
         tte_pkg::CSR_TOLERANCE_PERCENT:  cfg_tol_pct    = data[tte_pkg::TOL_W-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   // Drop valid, wait for every expected item, then let a tap that causes no item finish.
   task automatic drain_results();
      int waited;
      @(negedge clock);
      req_valid = 1'b0;
      waited = 0;
      while (pending_tempo.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_tempo.size() != 0) begin
         report_mismatch($sformatf("%0d expected tempo items never came out",
                                   pending_tempo.size()));
         pending_tempo.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Receiver: wait the drawn number of cycles after each item, and hold off while frozen.
   always @(negedge clock) begin
      if (rsp_frozen) begin
         rsp_ready = 1'b0;
      end else if (rsp_stall_left != 0) begin
         rsp_ready = 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // Long hold-off of the receiver, counted here on its own.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_freeze_len != 0) begin
            rsp_frozen = 1'b1;
            repeat (rsp_freeze_len) @(posedge clock);
            rsp_frozen = 1'b0;
            rsp_freeze_len = 0;
         end
      end
   end

   // Compare each tempo item taken from the block with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_stall_left = rsp_stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
         tempo_checked++;
         if (pending_tempo.size() == 0) begin
            report_mismatch($sformatf("unexpected tempo item beat_time %0h period %0d",
                                      rsp_beat_time, rsp_quarter_period));
         end else begin
            tempo_want = pending_tempo.pop_front();
            if (rsp_beat_time !== tempo_want.beat_time)
               report_mismatch($sformatf("beat_time got %0h want %0h",
                                         rsp_beat_time, tempo_want.beat_time));
            if (rsp_quarter_period !== tempo_want.quarter_period)
               report_mismatch($sformatf("quarter_period got %0d want %0d (beat %0h)",
                                         rsp_quarter_period, tempo_want.quarter_period,
                                         tempo_want.beat_time));
            if (rsp_intervals_used !== tempo_want.intervals_used)
               report_mismatch($sformatf("intervals_used got %0d want %0d (beat %0h)",
                                         rsp_intervals_used, tempo_want.intervals_used,
                                         tempo_want.beat_time));
         end
      end
   end

   // Fill the ring from empty under the reset registers: no item for the first tap,
   // then one, two and three intervals, a too-long interval, one exactly at the limit,
   // a zero interval, the top tap time, a wrap past zero and a tap that goes backwards.
   task automatic test_ring_fill();
      send_tap(32'h0000_0000);
      send_tap(32'd1000);
      send_tap(32'd2000);
      send_tap(32'd3000);
      send_tap(32'd5001);
      send_tap(32'd7001);
      send_tap(32'd7001);
      send_tap(32'hFFFF_FFFF);
      tap_after(32'd1500);
      send_tap(32'h0000_0100);
   endtask

   // Older intervals right at, just inside and just past ten percent of the newest.
   task automatic test_tolerance_edges();
      tap_after(32'd1110);
      tap_after(32'd1100);
      tap_after(32'd1000);
      tap_after(32'd1101);
      tap_after(32'd1000);
      tap_after(32'd900);
      tap_after(32'd1000);
   endtask

   // Register extremes: a saturated average at the widest settings, writes to spare
   // indexes and unused upper bits, then the tightest settings.
   task automatic test_limits();
      drain_results();
      write_csr(tte_pkg::CSR_MAX_QUARTER_PERIOD, 16'hFFFF);
      write_csr(tte_pkg::CSR_TOLERANCE_PERCENT, 16'hFF80 | 16'd100);
      write_csr(CSR_SPARE_2, 16'hFFFF);
      write_csr(CSR_SPARE_3, 16'h0000);
      tap_after(32'd131070);
      tap_after(32'd131070);
      tap_after(32'd131070);
      tap_after(32'd65535);
      drain_results();
      write_csr(tte_pkg::CSR_MAX_QUARTER_PERIOD, 16'd1);
      write_csr(tte_pkg::CSR_TOLERANCE_PERCENT, 16'd0);
      tap_after(32'd1);
      tap_after(32'd1);
      tap_after(32'd1);
      tap_after(32'd2);
      tap_after(32'd0);
   endtask

   // Freeze the receiver while taps keep coming back to back, so the block fills up
   // and must stall its input.
   task automatic test_output_stall();
      int k;
      drain_results();
      write_csr(tte_pkg::CSR_MAX_QUARTER_PERIOD, 16'd2000);
      write_csr(tte_pkg::CSR_TOLERANCE_PERCENT, 16'd10);
      tap_gaps_on = 1'b0;
      rsp_freeze_len = HOLD_OFF_LEN;
      for (k = 0; k < 10; k++) tap_after(32'($urandom_range(480, 520)));
      tap_gaps_on = 1'b1;
   endtask

   // Random phases, each under its own register setting. Most taps come in bursts
   // around one period with jitter near the tolerance; the rest are zero gaps, gaps
   // at the limit, wild jumps and halved or doubled periods.
   task automatic test_random_taps();
      int                             phase;
      int                             k;
      int                             roll;
      int                             burst_left;
      int unsigned                    base_gap;
      int unsigned                    jitter;
      logic [tte_pkg::TAP_W-1:0]      gap;
      logic [tte_pkg::QP_W-1:0]       max_set;
      logic [tte_pkg::TOL_W-1:0]      tol_set;
      logic [tte_pkg::CSR_DATA_W-1:0] wdata;

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         case (phase)
            0: begin max_set = 16'hFFFF; tol_set = 7'd100; end
            1: begin max_set = 16'd1;    tol_set = 7'd0;   end
            2: begin max_set = tte_pkg::MAX_QP_RESET; tol_set = tte_pkg::TOL_RESET; end
            3: begin max_set = 16'hFFFF; tol_set = 7'd0;   end
            default: begin
               max_set = tte_pkg::QP_W'($urandom_range(1, 65535));
               tol_set = tte_pkg::TOL_W'($urandom_range(0, 100));
            end
         endcase
         // Fill the unused upper bits of the tolerance write with noise.
         write_csr(tte_pkg::CSR_MAX_QUARTER_PERIOD, max_set);
         wdata = tte_pkg::CSR_DATA_W'($urandom);
         wdata[tte_pkg::TOL_W-1:0] = tol_set;
         write_csr(tte_pkg::CSR_TOLERANCE_PERCENT, wdata);
         if ($urandom_range(0, 1) == 1)
            write_csr($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3,
                      tte_pkg::CSR_DATA_W'($urandom));

         // Leave some phases without idling on one side or the other.
         tap_gaps_on   = (phase % 3 != 1);
         rsp_stalls_on = (phase % 4 != 2);

         burst_left = 0;
         base_gap   = 1;
         for (k = 0; k < PHASE_TAPS; k++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(4, 12);
               case ($urandom_range(0, 3))
                  0, 1: base_gap = $urandom_range(1, max_set);
                  2:    base_gap = $urandom_range(max_set - max_set / 4, max_set);
                  default: base_gap = $urandom_range(1, (max_set < 64) ? max_set : 64);
               endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < 72) begin
               jitter = base_gap * $urandom_range(0, tol_set + 3) / tte_pkg::PCT_SCALE;
               if ($urandom_range(0, 1) == 1 || jitter > base_gap) gap = base_gap + jitter;
               else gap = base_gap - jitter;
            end else if (roll < 78) begin
               gap = '0;
            end else if (roll < 84) begin
               gap = tte_pkg::TAP_W'(max_set) + tte_pkg::TAP_W'($urandom_range(0, 1));
            end else if (roll < 92) begin
               gap = $urandom;
            end else begin
               gap = $urandom_range(0, 1) ? base_gap * 2 : base_gap / 2;
            end
            tap_after(gap);
            burst_left--;
         end
      end
      tap_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   initial begin
      // Predictor starts from the reset state of the block.
      ring_head      = 0;
      ring_fill      = 0;
      cfg_max_period = tte_pkg::MAX_QP_RESET;
      cfg_tol_pct    = tte_pkg::TOL_RESET;
      foreach (tap_ring[i]) tap_ring[i] = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_ring_fill();
      test_tolerance_edges();
      test_limits();
      test_output_stall();
      test_random_taps();
      drain_results();

      $display("Covered %0d taps: ring fill, tolerance edges, register extremes,",
               taps_sent);
      $display("a %0d-cycle output hold-off and random bursts; %0d tempo items, %0d writes",
               HOLD_OFF_LEN, tempo_checked, csr_writes);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/tte_pkg.sv
hdl/tte_ctrl.sv
hdl/tte_dp.sv
hdl/tap_tempo_estimator_core.sv
tb/tb_tap_tempo_estimator_core.sv
